// ===== rtl/pirf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirf_pkg
// Shared constants and controller/datapath interface types for the PMU
// register file behind the I2C target.
// ----------------------------------------------------------------------------
package pirf_pkg;

    localparam int REGISTER_COUNT_DEF = 256;
    localparam int PTR_W              = 8;
    localparam int DATA_W             = 8;
    localparam int BAT_W              = 10;

    localparam logic [BAT_W-1:0] BATTERY_DEFAULT = 10'd895;

    // bus event codes carried in tuser
    localparam logic [1:0] MODE_WSTART = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_OTHER  = 2'd3;

    // register map
    localparam logic [PTR_W-1:0] ADDR_IRQ_FIRST   = 8'h02;
    localparam logic [PTR_W-1:0] ADDR_IRQ_LAST    = 8'h06;
    localparam logic [PTR_W-1:0] ADDR_SHUTDOWN    = 8'h0c;
    localparam logic [PTR_W-1:0] ADDR_STATUS      = 8'h12;
    localparam logic [PTR_W-1:0] ADDR_GPIO_CFG    = 8'h16;
    localparam logic [PTR_W-1:0] ADDR_ADC_CTRL    = 8'h54;
    localparam logic [PTR_W-1:0] ADDR_ADC_RES_HI  = 8'h55;
    localparam logic [PTR_W-1:0] ADDR_ADC_RES_MID = 8'h56;
    localparam logic [PTR_W-1:0] ADDR_ADC_RES_LO  = 8'h57;
    localparam logic [PTR_W-1:0] ADDR_IRQ_EXT     = 8'h85;
    localparam logic [PTR_W-1:0] ADDR_GPIO_STAT   = 8'h87;

    localparam logic [DATA_W-1:0] GPIO_CFG_RESET  = 8'h07;
    localparam logic [DATA_W-1:0] SHUTDOWN_OR     = 8'h08;
    localparam logic [DATA_W-1:0] GPIO_STAT_OR    = 8'h02;
    localparam logic [DATA_W-1:0] STATUS_VALUE    = 8'h08;
    localparam logic [DATA_W-1:0] ADC_READY       = 8'h80;
    localparam logic [DATA_W-1:0] ADC_MUX_MASK    = 8'hf0;
    localparam logic [DATA_W-1:0] ADC_MUX_BAT0    = 8'h00;
    localparam logic [DATA_W-1:0] ADC_MUX_BAT1    = 8'h10;

    // controller -> datapath
    typedef struct packed {
        logic clr_we;   // clearing pass write
        logic take;     // input word accepted this cycle
        logic rd_done;  // RAM read data valid, finish the read
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic out_free; // output register empty or being drained
        logic is_read;  // incoming word is a read
    } t_sts;

endpackage

// ===== rtl/pirf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pirf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pirf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirf_ctrl
// Sequencer: clearing pass after reset, word acceptance, read completion.
// ----------------------------------------------------------------------------
module pirf_ctrl
    import pirf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign take    = o_ready && i_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.clr_we  = 1'b0;
        o_cmd.take    = 1'b0;
        o_cmd.rd_done = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = !i_sts.clr_done;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.take = take;
                if (take && i_sts.is_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_done = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/pirf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pirf_dp
// Datapath: register RAM, pointer and latch, ADC result registers, read
// overrides, output register.
// ----------------------------------------------------------------------------
module pirf_dp
    import pirf_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [1:0]        i_mode,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_cfg_we,
    input  logic [BAT_W-1:0]  i_cfg_wdata,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_out_data,
    input  logic              i_out_ready
);

    localparam int ADDR_W = $clog2(REGISTER_COUNT);

    logic [PTR_W-1:0]  r_ptr;
    logic              r_latched;
    logic [BAT_W-1:0]  r_bat;
    logic [DATA_W-1:0] r_res_hi;
    logic [DATA_W-1:0] r_res_mid;
    logic [DATA_W-1:0] r_res_lo;
    logic [ADDR_W:0]   r_clr_cnt;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic              wr_store;
    logic              adc_start;
    logic [BAT_W-1:0]  adc_sel;
    logic [DATA_W-1:0] rd_value;
    logic              out_load;
    logic [DATA_W-1:0] out_value;

    // store path: a write byte after the pointer is latched
    assign wr_store  = i_cmd.take && (i_mode == MODE_WRITE) && r_latched;
    assign adc_start = wr_store && (r_ptr == ADDR_ADC_CTRL) && i_wdata[0];
    assign adc_sel   = (((i_wdata & ADC_MUX_MASK) == ADC_MUX_BAT0) ||
                        ((i_wdata & ADC_MUX_MASK) == ADC_MUX_BAT1)) ? r_bat : '0;

    always_comb begin
        if (i_cmd.clr_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt[ADDR_W-1:0];
            ram_wdata = (PTR_W'(r_clr_cnt[ADDR_W-1:0]) == ADDR_GPIO_CFG) ? GPIO_CFG_RESET : '0;
        end else begin
            ram_we    = wr_store;
            ram_waddr = r_ptr[ADDR_W-1:0];
            ram_wdata = i_wdata;
        end
    end

    pirf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REGISTER_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // read overrides, ADC results live in flops
    always_comb begin
        if (r_ptr == ADDR_SHUTDOWN) begin
            rd_value = ram_rdata | SHUTDOWN_OR;
        end else if (r_ptr == ADDR_GPIO_STAT) begin
            rd_value = ram_rdata | GPIO_STAT_OR;
        end else if ((r_ptr >= ADDR_IRQ_FIRST && r_ptr <= ADDR_IRQ_LAST) ||
                     r_ptr == ADDR_IRQ_EXT) begin
            rd_value = '0;
        end else if (r_ptr == ADDR_STATUS) begin
            rd_value = STATUS_VALUE;
        end else if (r_ptr == ADDR_ADC_RES_HI) begin
            rd_value = r_res_hi;
        end else if (r_ptr == ADDR_ADC_RES_MID) begin
            rd_value = r_res_mid;
        end else if (r_ptr == ADDR_ADC_RES_LO) begin
            rd_value = r_res_lo;
        end else begin
            rd_value = ram_rdata;
        end
    end

    assign out_load  = (i_cmd.take && (i_mode != MODE_READ)) || i_cmd.rd_done;
    assign out_value = i_cmd.rd_done ? rd_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_latched   <= 1'b0;
            r_bat       <= BATTERY_DEFAULT;
            r_res_hi    <= '0;
            r_res_mid   <= '0;
            r_res_lo    <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bat <= i_cfg_wdata;
            end
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.take && (i_mode == MODE_WSTART)) begin
                r_latched <= 1'b0;
            end
            if (i_cmd.take && (i_mode == MODE_WRITE) && !r_latched) begin
                r_ptr     <= i_wdata;
                r_latched <= 1'b1;
            end
            if (wr_store) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_ptr == ADDR_ADC_RES_HI) begin
                    r_res_hi <= i_wdata;
                end
                if (r_ptr == ADDR_ADC_RES_MID) begin
                    r_res_mid <= i_wdata;
                end
                if (r_ptr == ADDR_ADC_RES_LO) begin
                    r_res_lo <= i_wdata;
                end
            end
            if (adc_start) begin
                r_res_hi  <= adc_sel[BAT_W-1:2];
                r_res_mid <= '0;
                r_res_lo  <= ADC_READY | {6'd0, adc_sel[1:0]};
            end
            if (i_cmd.rd_done) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_value;
        end
    end

    assign o_sts.clr_done = r_clr_cnt[ADDR_W];
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.is_read  = (i_mode == MODE_READ);
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    // no word is taken before the clearing pass has finished
    a_take_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> r_clr_cnt[ADDR_W])
        else $error("word accepted during clearing pass");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // a finished read advances the pointer by one
    a_read_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_done |=> (r_ptr == $past(r_ptr) + 1'b1))
        else $error("pointer did not advance after read");

    // the clearing pass and normal traffic never share the write port
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_we |-> !(i_cmd.take || i_cmd.rd_done))
        else $error("clearing write overlaps traffic");

endmodule

// ===== rtl/pmu_i2c_register_file_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_i2c_register_file_core
// Register file of a power-management chip as seen behind an I2C target:
// 256 byte registers, a register pointer loaded by the first written byte,
// auto-increment on writes and reads, ADC conversion on start-bit writes.
// ----------------------------------------------------------------------------
//
//  port group   dir  fields (lsb first)                 accepted when
//  s_axis_*     in   tuser: mode[1:0]; tdata: wdata[7:0] tvalid & tready
//  m_axis_*     out  tdata: read_data[7:0]               tvalid & tready
//  i_cfg_*      in   wdata: battery_adc_count[9:0]       i_cfg_we
//
//  After reset a clearing pass loads the reset image into all REGISTER_COUNT
//  RAM registers; s_axis_tready stays low until the pass is done and the sequencer is idle.
//  Write-start, write-byte and ignored words are handled in the idle state.
//  A read also passes through the read state: the register RAM has a registered read port.
//  Each word yields one result word; the output register frees the input
//  side, so a new word is taken in the cycle a pending result is drained.
//  Reset is synchronous, active low.
//
module pmu_i2c_register_file_core
    import pirf_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] write_data
    input  logic [1:0]        s_axis_tuser,   // [1:0] mode
    // result words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] read_data
    // configuration: battery ADC count
    input  logic              i_cfg_we,
    input  logic [BAT_W-1:0]  i_cfg_wdata
);

    t_cmd cmd;   // sequencer commands
    t_sts sts;   // datapath status

    pirf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pirf_dp #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (s_axis_tuser),
        .i_wdata     (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule
